>>> src/dqts_pkg.sv
// ----------------------------------------------------------------------------
// dqts_pkg: shared types and constants of the delta queue timer scheduler
// Item layouts, list entry layout, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package dqts_pkg;

	localparam int unsigned MAX_TASKS = 16;
	localparam int unsigned TIME_BITS = 32;
	localparam int unsigned IDX_W     = $clog2(MAX_TASKS);
	localparam int unsigned LINK_W    = IDX_W + 1;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_TASKS);
	localparam logic [31:0] DEFAULT_SLEEP  = 32'd250000;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_RELOAD = 2'd1,
		KIND_ACK    = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic {
		ACT_REGISTER = 1'b0,
		ACT_TICK     = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [3:0]  task_id;
		logic [31:0] interval_us;
		logic [31:0] elapsed_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  fired_task;
		logic [31:0] reload_us;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [LINK_W-1:0]    link;
		logic [TIME_BITS-1:0] period;
		logic [TIME_BITS-1:0] delta;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_START,
		ST_T_SUB,
		ST_F_START,
		ST_F_CHK,
		ST_EMIT,
		ST_PL_START,
		ST_PL_HEAD,
		ST_PL_WALK,
		ST_PL_CUR,
		ST_PL_WRP,
		ST_PL_WRI
	} state_t;

	localparam logic [0:0] REG_SLEEP = 1'b0;

endpackage

>>> src/delta_queue_timer_scheduler_unit.sv
// ----------------------------------------------------------------------------
// delta_queue_timer_scheduler_unit: periodic task scheduler on a delta list
// Register item: a rejected one yields its single result directly, an
// accepted one after its list insertion.
// Tick: charges elapsed time entry by entry, then per fired task emits a
// result and does one list insertion, then emits a closing reload result;
// one item in flight at a time.
// Reset: list empty, no task used, sleep_interval 250000, no result pending.
// ----------------------------------------------------------------------------
module delta_queue_timer_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	// item input
	input  logic                req_valid,
	output logic                req_stall,
	input  dqts_pkg::in_item_t  req,
	// result output
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dqts_pkg::out_item_t rsp,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned IW = dqts_pkg::IDX_W;
	localparam int unsigned LW = dqts_pkg::LINK_W;
	localparam int unsigned TW = dqts_pkg::TIME_BITS;

	// Sequencer state and list bookkeeping.
	dqts_pkg::state_t        state_q, state_d;
	logic [LW-1:0]           head_q;
	logic [dqts_pkg::MAX_TASKS-1:0] used_q;
	logic [31:0]             sleep_q;

	// Working registers of the current insertion or walk.
	logic [IW-1:0]           i_q;        // entry being placed
	logic [TW-1:0]           d_q;        // remaining delta to place
	logic [TW-1:0]           per_q;      // period of the entry being placed
	logic [LW-1:0]           nxt_q;      // successor chosen for the entry
	logic [LW-1:0]           cur_q;      // entry under the walk
	logic [IW-1:0]           prev_idx_q; // predecessor in the walk
	dqts_pkg::entry_t        prev_word_q;
	logic [31:0]             el_q;       // elapsed time still to charge
	logic                    tick_q;     // placement belongs to a tick
	logic                    new_head_q; // placed entry became head

	// Pending result and output register.
	dqts_pkg::out_item_t     res_q;
	dqts_pkg::out_item_t     out_q;
	logic                    out_valid_q;
	logic                    out_free;
	logic                    emit_load;

	// Memory port.
	logic                    wr_en, rd_en;
	logic [IW-1:0]           wr_addr, rd_addr;
	dqts_pkg::entry_t        wr_data, r;

	logic                    req_take;
	logic [TW-1:0]           clamp_iv;
	logic                    head_nil, cur_nil;

	dqts_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (r)
	);

	assign req_stall = (state_q != dqts_pkg::ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign head_nil  = (head_q == dqts_pkg::NIL_LINK);
	assign cur_nil   = (cur_q == dqts_pkg::NIL_LINK);
	assign clamp_iv  = (req.interval_us == 32'd0) ? TW'(1) : TW'(req.interval_us);
	assign out_free  = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Configuration port: one register, always ready.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == dqts_pkg::REG_SLEEP) ? sleep_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_q <= dqts_pkg::DEFAULT_SLEEP;
		end else if (psel && penable && pwrite && (paddr[2] == dqts_pkg::REG_SLEEP)) begin
			sleep_q <= pwdata;
		end
	end

	// Next state, memory access and result handoff.
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = cur_q[IW-1:0];
		wr_en     = 1'b0;
		wr_addr   = cur_q[IW-1:0];
		wr_data   = r;
		emit_load = 1'b0;
		case (state_q)
			dqts_pkg::ST_IDLE: begin
				if (req_take) begin
					if (req.action == dqts_pkg::ACT_TICK) begin
						state_d = dqts_pkg::ST_T_START;
					end else if (used_q[req.task_id]) begin
						state_d = dqts_pkg::ST_EMIT;
					end else begin
						state_d = dqts_pkg::ST_PL_START;
					end
				end
			end
			dqts_pkg::ST_T_START: begin
				if (head_nil) begin
					state_d = dqts_pkg::ST_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q[IW-1:0];
					state_d = dqts_pkg::ST_T_SUB;
				end
			end
			dqts_pkg::ST_T_SUB: begin
				// charge elapsed time to this entry, saturating at zero
				wr_en = 1'b1;
				if (r.delta >= TW'(el_q)) begin
					wr_data.delta = r.delta - TW'(el_q);
					state_d = dqts_pkg::ST_F_START;
				end else begin
					wr_data.delta = '0;
					if (r.link == dqts_pkg::NIL_LINK) begin
						state_d = dqts_pkg::ST_F_START;
					end else begin
						rd_en   = 1'b1;
						rd_addr = r.link[IW-1:0];
					end
				end
			end
			dqts_pkg::ST_F_START: begin
				if (head_nil) begin
					state_d = dqts_pkg::ST_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q[IW-1:0];
					state_d = dqts_pkg::ST_F_CHK;
				end
			end
			dqts_pkg::ST_F_CHK: begin
				state_d = dqts_pkg::ST_EMIT;
			end
			dqts_pkg::ST_EMIT: begin
				if (out_free) begin
					emit_load = 1'b1;
					state_d = res_q.last ? dqts_pkg::ST_IDLE : dqts_pkg::ST_PL_START;
				end
			end
			dqts_pkg::ST_PL_START: begin
				if (head_nil) begin
					state_d = dqts_pkg::ST_PL_WRI;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q[IW-1:0];
					state_d = dqts_pkg::ST_PL_HEAD;
				end
			end
			dqts_pkg::ST_PL_HEAD: begin
				if (r.delta > d_q) begin
					// new entry goes in front: shorten the old head
					wr_en         = 1'b1;
					wr_addr       = head_q[IW-1:0];
					wr_data.delta = r.delta - d_q;
					state_d       = dqts_pkg::ST_PL_WRI;
				end else begin
					state_d = dqts_pkg::ST_PL_WALK;
				end
			end
			dqts_pkg::ST_PL_WALK: begin
				if (cur_nil) begin
					// append after the tail
					wr_en        = 1'b1;
					wr_addr      = prev_idx_q;
					wr_data      = prev_word_q;
					wr_data.link = LW'(i_q);
					state_d      = dqts_pkg::ST_PL_WRI;
				end else begin
					rd_en   = 1'b1;
					state_d = dqts_pkg::ST_PL_CUR;
				end
			end
			dqts_pkg::ST_PL_CUR: begin
				if (d_q <= r.delta) begin
					wr_en         = 1'b1;
					wr_data.delta = r.delta - d_q;
					state_d       = dqts_pkg::ST_PL_WRP;
				end else begin
					state_d = dqts_pkg::ST_PL_WALK;
				end
			end
			dqts_pkg::ST_PL_WRP: begin
				wr_en        = 1'b1;
				wr_addr      = prev_idx_q;
				wr_data      = prev_word_q;
				wr_data.link = LW'(i_q);
				state_d      = dqts_pkg::ST_PL_WRI;
			end
			dqts_pkg::ST_PL_WRI: begin
				wr_en          = 1'b1;
				wr_addr        = i_q;
				wr_data.link   = nxt_q;
				wr_data.period = per_q;
				wr_data.delta  = d_q;
				state_d = tick_q ? dqts_pkg::ST_F_START : dqts_pkg::ST_EMIT;
			end
			default: begin
				state_d = dqts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// List control: head pointer and used flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= dqts_pkg::NIL_LINK;
			used_q <= '0;
		end else begin
			case (state_q)
				dqts_pkg::ST_IDLE: begin
					if (req_take && req.action == dqts_pkg::ACT_REGISTER) begin
						used_q[req.task_id] <= 1'b1;
					end
				end
				dqts_pkg::ST_F_CHK: begin
					// unlink the due head
					if (r.delta == '0) begin
						head_q <= r.link;
					end
				end
				dqts_pkg::ST_PL_START: begin
					if (head_nil) begin
						head_q <= LW'(i_q);
					end
				end
				dqts_pkg::ST_PL_HEAD: begin
					if (r.delta > d_q) begin
						head_q <= LW'(i_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers and pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			dqts_pkg::ST_IDLE: begin
				if (req_take) begin
					i_q        <= req.task_id;
					d_q        <= clamp_iv;
					per_q      <= clamp_iv;
					el_q       <= req.elapsed_us;
					tick_q     <= req.action;
					new_head_q <= 1'b0;
					res_q      <= '{kind: dqts_pkg::KIND_REJECT, fired_task: 4'd0,
						reload_us: 32'd0, last: 1'b1};
				end
			end
			dqts_pkg::ST_T_START: begin
				cur_q <= head_q;
				res_q <= '{kind: dqts_pkg::KIND_RELOAD, fired_task: 4'd0,
					reload_us: sleep_q, last: 1'b1};
			end
			dqts_pkg::ST_T_SUB: begin
				if (r.delta < TW'(el_q)) begin
					el_q  <= el_q - 32'(r.delta);
					cur_q <= r.link;
				end
			end
			dqts_pkg::ST_F_START: begin
				cur_q <= head_q;
				res_q <= '{kind: dqts_pkg::KIND_RELOAD, fired_task: 4'd0,
					reload_us: sleep_q, last: 1'b1};
			end
			dqts_pkg::ST_F_CHK: begin
				if (r.delta != '0) begin
					res_q <= '{kind: dqts_pkg::KIND_RELOAD, fired_task: 4'd0,
						reload_us: 32'(r.delta), last: 1'b1};
				end else begin
					// fire and put it back with its own period
					res_q      <= '{kind: dqts_pkg::KIND_FIRED, fired_task: 4'(cur_q[IW-1:0]),
						reload_us: 32'd0, last: 1'b0};
					i_q        <= cur_q[IW-1:0];
					d_q        <= r.period;
					per_q      <= r.period;
					new_head_q <= 1'b0;
				end
			end
			dqts_pkg::ST_PL_START: begin
				if (head_nil) begin
					nxt_q      <= dqts_pkg::NIL_LINK;
					new_head_q <= 1'b1;
				end
			end
			dqts_pkg::ST_PL_HEAD: begin
				if (r.delta > d_q) begin
					nxt_q      <= head_q;
					new_head_q <= 1'b1;
				end else begin
					d_q         <= d_q - r.delta;
					prev_idx_q  <= head_q[IW-1:0];
					prev_word_q <= r;
					cur_q       <= r.link;
				end
			end
			dqts_pkg::ST_PL_WALK: begin
				if (cur_nil) begin
					nxt_q <= dqts_pkg::NIL_LINK;
				end
			end
			dqts_pkg::ST_PL_CUR: begin
				if (d_q <= r.delta) begin
					nxt_q <= cur_q;
				end else begin
					d_q         <= d_q - r.delta;
					prev_idx_q  <= cur_q[IW-1:0];
					prev_word_q <= r;
					cur_q       <= r.link;
				end
			end
			dqts_pkg::ST_PL_WRI: begin
				if (new_head_q) begin
					res_q <= '{kind: dqts_pkg::KIND_RELOAD, fired_task: 4'd0,
						reload_us: 32'(d_q), last: 1'b1};
				end else begin
					res_q <= '{kind: dqts_pkg::KIND_ACK, fired_task: 4'd0,
						reload_us: 32'd0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold while stalled, load a pending result when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q <= res_q;
		end
	end

endmodule

>>> src/dqts_ram.sv
// ----------------------------------------------------------------------------
// dqts_ram: entry store of the scheduler
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dqts_ram (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [dqts_pkg::IDX_W-1:0]       wr_addr,
	input  dqts_pkg::entry_t                 wr_data,
	input  logic                             rd_en,
	input  logic [dqts_pkg::IDX_W-1:0]       rd_addr,
	output dqts_pkg::entry_t                 rd_data
);

	dqts_pkg::entry_t mem [dqts_pkg::MAX_TASKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> tb/delta_queue_timer_scheduler_unit_chk.sv
// ----------------------------------------------------------------------------
// delta_queue_timer_scheduler_unit_chk: result checker for the scheduler
// Watches both item channels and the register port, keeps its own copy of
// the delta list, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module delta_queue_timer_scheduler_unit_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  dqts_pkg::in_item_t  req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  dqts_pkg::out_item_t rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending_count
);

	localparam int NIL = dqts_pkg::MAX_TASKS;

	logic [31:0] sleep_us;
	logic [31:0] dl_delta [dqts_pkg::MAX_TASKS];
	logic [31:0] dl_period [dqts_pkg::MAX_TASKS];
	int          dl_next [dqts_pkg::MAX_TASKS];
	bit          dl_used [dqts_pkg::MAX_TASKS];
	int          dl_head;
	dqts_pkg::out_item_t sched_expected [$];

	assign pending_count = sched_expected.size();

	function automatic void push_result(logic [1:0] k, logic [3:0] t, logic [31:0] r,
			logic l);
		dqts_pkg::out_item_t o;
		o.kind = k;
		o.fired_task = t;
		o.reload_us = r;
		o.last = l;
		sched_expected.push_back(o);
	endfunction

	// insert entry i, its delta grown by its period; return 1 if it became head
	function automatic bit place_task(int i);
		logic [32:0] sum;
		logic [31:0] d;
		int prv;
		int cur;
		sum = {1'b0, dl_delta[i]} + {1'b0, dl_period[i]};
		d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (dl_head == NIL) begin
			dl_next[i] = NIL;
			dl_delta[i] = d;
			dl_head = i;
			return 1;
		end
		prv = dl_head;
		if (dl_delta[prv] > d) begin
			dl_delta[prv] -= d;
			dl_next[i] = prv;
			dl_delta[i] = d;
			dl_head = i;
			return 1;
		end
		d -= dl_delta[prv];
		cur = dl_next[prv];
		for (int g = 0; cur != NIL && g < dqts_pkg::MAX_TASKS; g++) begin
			if (d <= dl_delta[cur]) begin
				dl_delta[cur] -= d;
				dl_next[i] = cur;
				dl_next[prv] = i;
				dl_delta[i] = d;
				return 0;
			end
			d -= dl_delta[cur];
			prv = cur;
			cur = dl_next[cur];
		end
		dl_next[prv] = i;
		dl_next[i] = NIL;
		dl_delta[i] = d;
		return 0;
	endfunction

	function automatic void predict_schedule(dqts_pkg::in_item_t it);
		int id;
		int cur;
		logic [31:0] el;
		logic [31:0] iv;
		id = it.task_id;
		if (it.action == dqts_pkg::ACT_REGISTER) begin
			if (dl_used[id]) begin
				push_result(dqts_pkg::KIND_REJECT, 4'd0, 32'd0, 1'b1);
				return;
			end
			iv = (it.interval_us == 0) ? 32'd1 : it.interval_us;
			dl_used[id] = 1;
			dl_period[id] = iv;
			dl_delta[id] = 0;
			dl_next[id] = NIL;
			if (place_task(id))
				push_result(dqts_pkg::KIND_RELOAD, 4'd0, dl_delta[id], 1'b1);
			else
				push_result(dqts_pkg::KIND_ACK, 4'd0, 32'd0, 1'b1);
			return;
		end
		if (dl_head == NIL) begin
			push_result(dqts_pkg::KIND_RELOAD, 4'd0, sleep_us, 1'b1);
			return;
		end
		// charge elapsed time along the list, saturating at zero
		el = it.elapsed_us;
		cur = dl_head;
		for (int g = 0; cur != NIL && g < dqts_pkg::MAX_TASKS; g++) begin
			if (dl_delta[cur] >= el) begin
				dl_delta[cur] -= el;
				break;
			end
			el -= dl_delta[cur];
			dl_delta[cur] = 0;
			cur = dl_next[cur];
		end
		// fire due heads and requeue them with their own period
		for (int g = 0; g < dqts_pkg::MAX_TASKS; g++) begin
			cur = dl_head;
			if (cur == NIL || dl_delta[cur] >= 1)
				break;
			push_result(dqts_pkg::KIND_FIRED, cur[3:0], 32'd0, 1'b0);
			dl_head = dl_next[cur];
			dl_next[cur] = NIL;
			void'(place_task(cur));
		end
		push_result(dqts_pkg::KIND_RELOAD, 4'd0,
			(dl_head != NIL) ? dl_delta[dl_head] : sleep_us, 1'b1);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dqts_pkg::out_item_t w;
		if (!arst_n) begin
			fail_count = 0;
			sleep_us = dqts_pkg::DEFAULT_SLEEP;
			dl_head = NIL;
			sched_expected.delete();
			for (int i = 0; i < dqts_pkg::MAX_TASKS; i++) begin
				dl_used[i] = 0;
				dl_next[i] = NIL;
				dl_delta[i] = 0;
				dl_period[i] = 0;
			end
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == dqts_pkg::REG_SLEEP)
				sleep_us = pwdata;
			if (rsp_valid && !rsp_stall) begin
				if (sched_expected.size() == 0) begin
					report_mismatch("unexpected result kind", 32'(rsp.kind), 32'd0);
				end else begin
					w = sched_expected.pop_front();
					if (rsp.kind !== w.kind)
						report_mismatch("kind", 32'(rsp.kind), 32'(w.kind));
					if (rsp.fired_task !== w.fired_task)
						report_mismatch("fired_task", 32'(rsp.fired_task),
							32'(w.fired_task));
					if (rsp.reload_us !== w.reload_us)
						report_mismatch("reload_us", rsp.reload_us, w.reload_us);
					if (rsp.last !== w.last)
						report_mismatch("last", 32'(rsp.last), 32'(w.last));
				end
			end
			if (req_valid && !req_stall)
				predict_schedule(req);
		end
	end
endmodule

>>> tb/delta_queue_timer_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// delta_queue_timer_scheduler_unit_tb: stimulus and verdict for the scheduler
// Registers tasks and sends ticks (directed corners, then random traffic)
// with random gaps and stalls, rewrites sleep_interval between phases and
// lets the checker decide whether every result was right.
// ----------------------------------------------------------------------------
module delta_queue_timer_scheduler_unit_tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	dqts_pkg::in_item_t  req;
	logic        rsp_valid;
	logic        rsp_stall;
	dqts_pkg::out_item_t rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending_count;
	int          idle_cycles;
	bit          gaps_on;
	bit          stalls_on;

	delta_queue_timer_scheduler_unit uut (.*);

	delta_queue_timer_scheduler_unit_chk chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// stall the result side at random while enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 0;
		end else begin
			rsp_stall <= stalls_on && ($urandom_range(99) < 23);
		end
	end

	// watchdog: count cycles in which neither channel moves an item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[delta_queue_timer_scheduler_unit] ERROR");
				$finish;
			end
		end
	end

	// hold the item until it is taken; maybe idle first
	task automatic send_item(logic act, logic [3:0] id, logic [31:0] iv, logic [31:0] el);
		while (gaps_on && $urandom_range(99) < 23) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req.action <= act;
		req.task_id <= id;
		req.interval_us <= iv;
		req.elapsed_us <= el;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// drop valid, drain all expected results, then let the block settle
	task automatic wait_quiet();
		req_valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_sleep(logic [31:0] v);
		psel <= 1;
		pwrite <= 1;
		paddr <= 3'd0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	function automatic logic [31:0] rand_time();
		case ($urandom_range(5))
			0: return $urandom_range(3);
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return $urandom();
			default: return $urandom_range(2000);
		endcase
	endfunction

	initial begin
		req_valid = 0;
		req = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		gaps_on = 0;
		stalls_on = 0;
		arst_n = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty tick, register corners, duplicate, overshoot
		send_item(dqts_pkg::ACT_TICK, 4'd0, 32'd0, 32'd5);
		send_item(dqts_pkg::ACT_REGISTER, 4'd0, 32'd0, 32'hFFFF_FFFF);
		send_item(dqts_pkg::ACT_REGISTER, 4'd0, 32'd9, 32'd0);
		send_item(dqts_pkg::ACT_REGISTER, 4'd15, 32'hFFFF_FFFF, 32'd0);
		send_item(dqts_pkg::ACT_REGISTER, 4'd3, 32'd50, 32'd0);
		send_item(dqts_pkg::ACT_REGISTER, 4'd7, 32'd20, 32'd0);
		send_item(dqts_pkg::ACT_REGISTER, 4'd9, 32'd50, 32'd0);
		send_item(dqts_pkg::ACT_TICK, 4'd15, 32'hFFFF_FFFF, 32'd0);
		send_item(dqts_pkg::ACT_TICK, 4'd0, 32'd0, 32'd19);
		send_item(dqts_pkg::ACT_TICK, 4'd0, 32'd0, 32'd1000);
		send_item(dqts_pkg::ACT_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
		send_item(dqts_pkg::ACT_REGISTER, 4'd7, 32'd1, 32'd0);
		wait_quiet();

		// extremes of sleep_interval
		write_sleep(32'hFFFF_FFFF);
		arst_n <= 1;
		gaps_on = 1;
		stalls_on = 1;
		// random: mostly ticks on a populated list, some registers
		for (int n = 0; n < 320; n++) begin
			if (n == 100) begin
				// sender holds off until every result is in
				wait_quiet();
				write_sleep(32'd1);
			end
			if (n == 200) begin
				wait_quiet();
				write_sleep(32'($urandom()) | 32'd1);
				gaps_on = 0;
				stalls_on = 0;
			end
			if (n == 260) begin
				gaps_on = 1;
				stalls_on = 1;
			end
			if ($urandom_range(99) < 45)
				send_item(dqts_pkg::ACT_REGISTER, 4'($urandom_range(15)), rand_time(),
					32'($urandom()));
			else
				send_item(dqts_pkg::ACT_TICK, 4'($urandom_range(15)), 32'($urandom()),
					rand_time());
		end
		wait_quiet();
		write_sleep(dqts_pkg::DEFAULT_SLEEP);
		send_item(dqts_pkg::ACT_TICK, 4'd0, 32'd0, 32'd0);
		wait_quiet();

		if (fail_count == 0)
			$display("[delta_queue_timer_scheduler_unit] OK");
		else
			$display("[delta_queue_timer_scheduler_unit] ERROR");
		$finish;
	end
endmodule
